// ----- rtl/hss_pkg.sv -----
`timescale 1ns / 1ps

package hss_pkg;

  localparam int REG_WIDTH       = 11;
  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BIAS    = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TENSION = 2'd1;

  localparam logic signed [REG_WIDTH-1:0] BIAS_RESET    = 11'sd51;
  localparam logic signed [REG_WIDTH-1:0] TENSION_RESET = 11'sd0;

  typedef struct packed {
    logic issue;
    logic clear;
  } mac_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ----- rtl/hss_mac.sv -----
`timescale 1ns / 1ps

module hss_mac #(
  parameter int OPA_WIDTH = 39,
  parameter int OPB_WIDTH = 12,
  parameter int ACC_WIDTH = 48
) (
  input  logic                        clk,
  input  logic                        rst,
  input  hss_pkg::mac_ctrl_t          ctrl,
  input  logic signed [OPA_WIDTH-1:0] op_a,
  input  logic signed [OPB_WIDTH-1:0] op_b,
  output logic signed [ACC_WIDTH-1:0] acc
);

  localparam int PW = OPA_WIDTH + OPB_WIDTH;
  localparam int EW = (PW > ACC_WIDTH) ? PW : ACC_WIDTH;

  logic signed [PW-1:0] prod;
  logic signed [EW-1:0] prod_ext;
  logic                 prod_valid;
  logic                 prod_clear;

  assign prod_ext = EW'(prod);

  // The product is registered; the accumulator adds it in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      prod_clear <= 1'b0;
    end else begin
      prod_valid <= ctrl.issue;
      prod_clear <= ctrl.clear;
    end
    prod <= op_a * op_b;
    if (prod_valid) begin
      if (prod_clear) begin
        acc <= prod_ext[ACC_WIDTH-1:0];
      end else begin
        acc <= acc + prod_ext[ACC_WIDTH-1:0];
      end
    end
  end

endmodule

// ----- rtl/hss_divider.sv -----
`timescale 1ns / 1ps

module hss_divider #(
  parameter int DIVIDEND_WIDTH = 40,
  parameter int DIVISOR_WIDTH  = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [DIVIDEND_WIDTH-1:0] dividend,
  input  logic        [DIVISOR_WIDTH-1:0]  divisor,
  output hss_pkg::div_status_t             status,
  output logic signed [DIVIDEND_WIDTH-1:0] quotient
);

  localparam int CW = $clog2(DIVIDEND_WIDTH + 1);

  logic                      busy;
  logic                      done;
  logic                      neg;
  logic [CW-1:0]             count;
  logic [DIVIDEND_WIDTH-1:0] shreg;
  logic [DIVISOR_WIDTH-1:0]  dsr;
  logic [DIVISOR_WIDTH-1:0]  rem;
  logic [DIVISOR_WIDTH:0]    rem_shift;
  logic [DIVISOR_WIDTH:0]    rem_diff;
  logic                      fits;

  assign rem_shift = {rem, shreg[DIVIDEND_WIDTH-1]};
  assign rem_diff  = rem_shift - {1'b0, dsr};
  assign fits      = (rem_shift >= {1'b0, dsr});

  // Restoring division on the magnitude, one quotient bit per cycle. The
  // magnitude register shifts out dividend bits and shifts in quotient bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= !start && busy && (count == CW'(1));
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(DIVIDEND_WIDTH);
        neg   <= dividend[DIVIDEND_WIDTH-1];
        shreg <= dividend[DIVIDEND_WIDTH-1] ? DIVIDEND_WIDTH'(-dividend)
                                            : DIVIDEND_WIDTH'(dividend);
        dsr   <= divisor;
        rem   <= '0;
      end else if (busy) begin
        rem   <= fits ? rem_diff[DIVISOR_WIDTH-1:0] : rem_shift[DIVISOR_WIDTH-1:0];
        shreg <= {shreg[DIVIDEND_WIDTH-2:0], fits};
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Floor quotient for a negative dividend: -q, or -q - 1 when a remainder is left.
  always_comb begin
    if (!neg) begin
      quotient = $signed(shreg);
    end else if (rem != '0) begin
      quotient = $signed(~shreg);
    end else begin
      quotient = $signed(-shreg);
    end
  end

  assign status = '{busy: busy, done: done};

endmodule

// ----- rtl/hermite_stroke_smoother.sv -----
`timescale 1ns / 1ps

// Hermite stroke smoother.
// Pen samples enter on the s_axis channel: tdata holds x and y (signed Q.4),
// tuser marks the first sample of a stroke. Path points leave on m_axis:
// tdata holds x and y, tuser marks the move-to point, tlast marks the last
// point caused by one sample. Bias and tension are written on the cfg
// channel (index 0 and 1, other indexes are dropped); write them only idle.
// A stroke start passes through S_MOVE and gives one move-to point. The
// second and third samples are only stored and give no point. Each later
// sample gives SUBDIVISIONS points. The bit-serial divider runs twice per
// point on QW bits, the accumulator width minus COEF_FRAC_BITS (40 at the
// defaults); one shared multiply-accumulate unit forms the tangents and
// the Hermite sums. s_tready is high only while idle.
// A finished point waits in the output register; if the receiver stalls, the
// sequencer holds until that register is free. Reset empties the window and
// restores bias 51 and tension 0; nothing is emitted until a sample arrives.

module hermite_stroke_smoother #(
  parameter int SUBDIVISIONS   = 4,
  parameter int COORD_WIDTH    = 20,
  parameter int COEF_FRAC_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // in_x, in_y
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]    s_tdata,
  // stroke_start
  input  logic                                  s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // out_x, out_y
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]    m_tdata,
  // is_move
  output logic                                  m_tuser,
  // last_of_run
  output logic                                  m_tlast,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [hss_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [hss_pkg::REG_WIDTH-1:0]         cfg_data
);

  import hss_pkg::*;

  localparam int W     = COORD_WIDTH;
  localparam int F     = COEF_FRAC_BITS;
  localparam int KW    = ((F > REG_WIDTH - 1) ? F : REG_WIDTH - 1) + 2;
  localparam int DW    = W + 1;
  localparam int GW    = W + KW + 3 - F;
  localparam int MW    = GW + KW;
  localparam int JW    = $clog2(SUBDIVISIONS ** 3 + 1);
  localparam int AW    = JW + 1;
  localparam int OPB   = (KW > AW) ? KW : AW;
  localparam int ACCW  = MW + JW + 2;
  localparam int AX    = ACCW + 1;
  localparam int QW    = ACCW - F;
  localparam int QX    = QW + 1;
  localparam int DVSW  = JW + 1;
  localparam int JCW   = $clog2(SUBDIVISIONS + 1);
  localparam int TDW   = ((2 * W + 7) / 8) * 8;
  localparam int SCALE = 2 ** F;
  localparam int HALF  = 2 ** (F - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE,
    S_PREP,
    S_TERMS,
    S_DIV_Y,
    S_DIV_X,
    S_EMIT
  } state_t;

  state_t state;
  logic [3:0]     st;
  logic [JCW-1:0] j;
  logic [1:0]     fill;

  logic signed [W-1:0] wx [3];
  logic signed [W-1:0] wy [3];
  logic signed [W-1:0] sx;
  logic signed [W-1:0] sy;
  logic signed [W-1:0] in_x;
  logic signed [W-1:0] in_y;

  logic signed [REG_WIDTH-1:0] bias;
  logic signed [REG_WIDTH-1:0] tension;

  logic signed [GW-1:0] g0;
  logic signed [GW-1:0] g1;
  logic signed [MW-1:0] m0;
  logic signed [MW-1:0] m1;
  logic signed [QW-1:0] qy;
  logic signed [QW-1:0] qx;

  logic signed [W-1:0] out_x;
  logic signed [W-1:0] out_y;
  logic                out_move;
  logic                out_last;
  logic                out_free;
  logic                out_load;

  logic signed [DW-1:0]  dy0;
  logic signed [DW-1:0]  dy1;
  logic signed [DW-1:0]  dy2;
  logic signed [DW-1:0]  dx;
  logic signed [OPB-1:0] coef_p;
  logic signed [OPB-1:0] coef_m;
  logic signed [OPB-1:0] coef_t;

  mac_ctrl_t              mac_ctrl;
  logic signed [MW-1:0]   mac_a;
  logic signed [OPB-1:0]  mac_b;
  logic signed [ACCW-1:0] acc;
  logic signed [ACCW-1:0] gsum;
  logic signed [AX-1:0]   ysum;
  logic signed [QW-1:0]   ydiv;
  logic signed [QW-1:0]   xdiv;

  logic                   div_start;
  logic signed [QW-1:0]   div_dividend;
  logic [DVSW-1:0]        div_divisor;
  div_status_t            div_stat;
  logic signed [QW-1:0]   div_quot;

  function automatic logic signed [AW-1:0] coef_a0(input logic [JCW-1:0] jv);
    int jj;
    jj = int'(jv);
    return AW'(jj * jj * jj - 3 * jj + 2);
  endfunction

  function automatic logic signed [AW-1:0] coef_a1(input logic [JCW-1:0] jv);
    int jj;
    jj = int'(jv);
    return AW'((jj - 1) * (jj - 1));
  endfunction

  function automatic logic signed [AW-1:0] coef_a2(input logic [JCW-1:0] jv);
    int jj;
    jj = int'(jv);
    return AW'(1 - jj);
  endfunction

  function automatic logic signed [AW-1:0] coef_a3(input logic [JCW-1:0] jv);
    int jj;
    jj = int'(jv);
    return AW'(3 * jj - 2);
  endfunction

  function automatic logic [JW-1:0] cube(input logic [JCW-1:0] jv);
    int jj;
    jj = int'(jv);
    return JW'(jj * jj * jj);
  endfunction

  // Clamp to the signed coordinate range when the upper bits are not all sign.
  function automatic logic signed [W-1:0] sat_coord(input logic signed [QX-1:0] v);
    logic all_one;
    logic all_zero;
    all_one  = &v[QX-1:W-1];
    all_zero = ~|v[QX-1:W-1];
    if (all_one || all_zero) begin
      return v[W-1:0];
    end else if (v[QX-1]) begin
      return {1'b1, {(W-1){1'b0}}};
    end else begin
      return {1'b0, {(W-1){1'b1}}};
    end
  endfunction

  assign in_x = s_tdata[W-1:0];
  assign in_y = s_tdata[2*W-1:W];

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = out_free && ((state == S_MOVE) || (state == S_EMIT));

  assign m_tdata = TDW'({out_y, out_x});
  assign m_tuser = out_move;
  assign m_tlast = out_last;

  assign dy0 = DW'(wy[1]) - DW'(wy[0]);
  assign dy1 = DW'(wy[2]) - DW'(wy[1]);
  assign dy2 = DW'(sy) - DW'(wy[2]);
  assign dx  = DW'(wx[2]) - DW'(wx[1]);

  assign coef_p = OPB'(SCALE) + OPB'(bias);
  assign coef_m = OPB'(SCALE) - OPB'(bias);
  assign coef_t = OPB'(SCALE) - OPB'(tension);

  assign gsum = acc + ACCW'(HALF);
  // Rounding y: floor((num + S j^3) / 2S) first, then the floor division by j^3.
  assign ysum = AX'(acc) + (AX'(cube(j)) <<< F);
  assign ydiv = QW'(ysum >>> (F + 1));
  assign xdiv = (QW'(dx) <<< 1) + QW'(j);

  // Operand schedule of the shared MAC. The product and then the accumulator
  // are registered after each issue, so some captures overlap the next issues.
  always_comb begin
    mac_ctrl = '0;
    mac_a    = '0;
    mac_b    = '0;
    unique case (state)
      S_PREP: begin
        unique case (st)
          4'd0: begin
            mac_a    = MW'(dy0);
            mac_b    = coef_p;
            mac_ctrl = '{issue: 1'b1, clear: 1'b1};
          end
          4'd1: begin
            mac_a    = MW'(dy1);
            mac_b    = coef_m;
            mac_ctrl = '{issue: 1'b1, clear: 1'b0};
          end
          4'd2: begin
            mac_a    = MW'(dy1);
            mac_b    = coef_p;
            mac_ctrl = '{issue: 1'b1, clear: 1'b1};
          end
          4'd3: begin
            mac_a    = MW'(dy2);
            mac_b    = coef_m;
            mac_ctrl = '{issue: 1'b1, clear: 1'b0};
          end
          4'd5: begin
            mac_a    = MW'(g0);
            mac_b    = coef_t;
            mac_ctrl = '{issue: 1'b1, clear: 1'b1};
          end
          4'd6: begin
            mac_a    = MW'(g1);
            mac_b    = coef_t;
            mac_ctrl = '{issue: 1'b1, clear: 1'b1};
          end
          default: begin
          end
        endcase
      end
      S_TERMS: begin
        unique case (st)
          4'd0: begin
            mac_a    = MW'(wy[1]) <<< (F + 1);
            mac_b    = OPB'(coef_a0(j));
            mac_ctrl = '{issue: 1'b1, clear: 1'b1};
          end
          4'd1: begin
            mac_a    = MW'(wy[2]) <<< (F + 1);
            mac_b    = OPB'(coef_a3(j));
            mac_ctrl = '{issue: 1'b1, clear: 1'b0};
          end
          4'd2: begin
            mac_a    = m0;
            mac_b    = OPB'(coef_a1(j));
            mac_ctrl = '{issue: 1'b1, clear: 1'b0};
          end
          4'd3: begin
            mac_a    = m1;
            mac_b    = OPB'(coef_a2(j));
            mac_ctrl = '{issue: 1'b1, clear: 1'b0};
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    div_start = ((state == S_TERMS) && (st == 4'd5)) ||
                ((state == S_DIV_Y) && div_stat.done);
    if (state == S_TERMS) begin
      div_dividend = ydiv;
      div_divisor  = DVSW'(cube(j));
    end else begin
      div_dividend = xdiv;
      div_divisor  = DVSW'(j) << 1;
    end
  end

  hss_mac #(
    .OPA_WIDTH (MW),
    .OPB_WIDTH (OPB),
    .ACC_WIDTH (ACCW)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .op_a (mac_a),
    .op_b (mac_b),
    .acc  (acc)
  );

  hss_divider #(
    .DIVIDEND_WIDTH (QW),
    .DIVISOR_WIDTH  (DVSW)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .status   (div_stat),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      st       <= '0;
      j        <= '0;
      fill     <= '0;
      m_tvalid <= 1'b0;
      bias     <= BIAS_RESET;
      tension  <= TENSION_RESET;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_BIAS) begin
          bias <= cfg_data;
        end else if (cfg_index == CFG_TENSION) begin
          tension <= cfg_data;
        end
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            sx <= in_x;
            sy <= in_y;
            if (s_tuser || (fill == 2'd0)) begin
              wx[0] <= '0;
              wy[0] <= '0;
              wx[1] <= '0;
              wy[1] <= '0;
              wx[2] <= in_x;
              wy[2] <= in_y;
              fill  <= 2'd1;
              state <= S_MOVE;
            end else if (fill != 2'd3) begin
              wx[0] <= wx[1];
              wy[0] <= wy[1];
              wx[1] <= wx[2];
              wy[1] <= wy[2];
              wx[2] <= in_x;
              wy[2] <= in_y;
              fill  <= fill + 2'd1;
            end else begin
              st    <= '0;
              state <= S_PREP;
            end
          end
        end
        S_MOVE: begin
          if (out_free) begin
            out_x    <= sx;
            out_y    <= sy;
            out_move <= 1'b1;
            out_last <= 1'b1;
            state    <= S_IDLE;
          end
        end
        S_PREP: begin
          if (st == 4'd3) begin
            g0 <= GW'(gsum >>> F);
          end
          if (st == 4'd5) begin
            g1 <= GW'(gsum >>> F);
          end
          if (st == 4'd7) begin
            m0 <= MW'(acc);
          end
          if (st == 4'd8) begin
            m1    <= MW'(acc);
            st    <= '0;
            j     <= JCW'(SUBDIVISIONS);
            state <= S_TERMS;
          end else begin
            st <= st + 4'd1;
          end
        end
        S_TERMS: begin
          st <= st + 4'd1;
          if (st == 4'd5) begin
            state <= S_DIV_Y;
          end
        end
        S_DIV_Y: begin
          if (div_stat.done) begin
            qy    <= div_quot;
            state <= S_DIV_X;
          end
        end
        S_DIV_X: begin
          if (div_stat.done) begin
            qx    <= div_quot;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_x    <= sat_coord(QX'(wx[1]) + QX'(qx));
            out_y    <= sat_coord(QX'(qy));
            out_move <= 1'b0;
            out_last <= (j == JCW'(1));
            if (j == JCW'(1)) begin
              // The window slides only after the last point of this sample.
              wx[0] <= wx[1];
              wy[0] <= wy[1];
              wx[1] <= wx[2];
              wy[1] <= wy[2];
              wx[2] <= sx;
              wy[2] <= sy;
              state <= S_IDLE;
            end else begin
              j     <= j - JCW'(1);
              st    <= '0;
              state <= S_TERMS;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_move_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("move-to point without last_of_run");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_ready_div_quiet: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !div_stat.busy)
    else $error("input ready while a division is running");

  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> ((state == S_DIV_Y) || (state == S_DIV_X)))
    else $error("divider finished outside a division wait");

  a_step_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_TERMS) |-> (j != '0))
    else $error("subdivision step reached zero inside the loop");

endmodule

// ----- tb/hss_checker.sv -----
`timescale 1ns / 1ps

module hss_checker #(
  parameter int SUBDIVISIONS   = 4,
  parameter int COORD_WIDTH    = 20,
  parameter int COEF_FRAC_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  input  logic                                  s_tready,
  // in_x, in_y
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]    s_tdata,
  // stroke_start
  input  logic                                  s_tuser,
  input  logic                                  m_tvalid,
  input  logic                                  m_tready,
  // out_x, out_y
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]    m_tdata,
  // is_move
  input  logic                                  m_tuser,
  // last_of_run
  input  logic                                  m_tlast,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [hss_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [hss_pkg::REG_WIDTH-1:0]         cfg_data,
  output int                                    mismatches,
  output int                                    pending,
  output int                                    points_checked
);

  import hss_pkg::*;

  localparam int CW = COORD_WIDTH;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 is_move;
    logic                 run_end;
  } path_point_t;

  logic signed [CW-1:0]        win_x [0:2];
  logic signed [CW-1:0]        win_y [0:2];
  int unsigned                 held;
  logic signed [REG_WIDTH-1:0] bias_q;
  logic signed [REG_WIDTH-1:0] tension_q;
  path_point_t                 points_due [$];
  int                          errors_seen = 0;
  int                          points_seen = 0;

  initial begin
    mismatches     = 0;
    pending        = 0;
    points_checked = 0;
  end

  function automatic longint floor_quot(input longint n, input longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && ((n < 0) != (d < 0))) q = q - 1;
    return q;
  endfunction

  // Nearest integer, ties toward +infinity.
  function automatic longint round_quot(input longint n, input longint d);
    return floor_quot(2 * n + d, 2 * d);
  endfunction

  function automatic logic signed [CW-1:0] clamp_coord(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) << (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[CW-1:0];
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d (path point %0d)",
             what, got, want, points_seen);
    errors_seen++;
  endtask

  task automatic shift_window(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
    win_x[0] = win_x[1];
    win_y[0] = win_y[1];
    win_x[1] = win_x[2];
    win_y[1] = win_y[2];
    win_x[2] = x;
    win_y[2] = y;
  endtask

  // Works out the path points one pen sample causes and queues them.
  task automatic smooth_sample(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                               input logic start);
    longint      s, b, t;
    longint      x1, x2, y0, y1, y2, y3;
    longint      g0, g1, m0, m1;
    longint      a0, a1, a2, a3, num, j;
    path_point_t pt;
    if (start || held == 0) begin
      win_x[0] = '0;
      win_y[0] = '0;
      win_x[1] = '0;
      win_y[1] = '0;
      win_x[2] = x;
      win_y[2] = y;
      held = 1;
      pt.x = x;
      pt.y = y;
      pt.is_move = 1'b1;
      pt.run_end = 1'b1;
      points_due.push_back(pt);
    end else if (held < 3) begin
      shift_window(x, y);
      held++;
    end else begin
      s  = longint'(1) << COEF_FRAC_BITS;
      b  = bias_q;
      t  = tension_q;
      x1 = win_x[1];
      x2 = win_x[2];
      y0 = win_y[0];
      y1 = win_y[1];
      y2 = win_y[2];
      y3 = y;
      g0 = round_quot((y1 - y0) * (s + b) + (y2 - y1) * (s - b), s);
      g1 = round_quot((y2 - y1) * (s + b) + (y3 - y2) * (s - b), s);
      m0 = g0 * (s - t);
      m1 = g1 * (s - t);
      for (j = SUBDIVISIONS; j > 0; j--) begin
        a0  = j * j * j - 3 * j + 2;
        a1  = j * j - 2 * j + 1;
        a2  = 1 - j;
        a3  = 3 * j - 2;
        num = 2 * s * (a0 * y1 + a3 * y2) + a1 * m0 + a2 * m1;
        pt.x = clamp_coord(x1 + round_quot(x2 - x1, j));
        pt.y = clamp_coord(round_quot(num, 2 * s * j * j * j));
        pt.is_move = 1'b0;
        pt.run_end = (j == 1);
        points_due.push_back(pt);
      end
      shift_window(x, y);
    end
  endtask

  task automatic check_point();
    path_point_t want;
    if (points_due.size() == 0) begin
      flag_mismatch("path point with none due, x", $signed(m_tdata[CW-1:0]), 0);
    end else begin
      want = points_due.pop_front();
      if (m_tdata[CW-1:0] !== want.x)
        flag_mismatch("out_x", $signed(m_tdata[CW-1:0]), want.x);
      if (m_tdata[2*CW-1:CW] !== want.y)
        flag_mismatch("out_y", $signed(m_tdata[2*CW-1:CW]), want.y);
      if (m_tuser !== want.is_move)
        flag_mismatch("is_move", m_tuser, want.is_move);
      if (m_tlast !== want.run_end)
        flag_mismatch("last_of_run", m_tlast, want.run_end);
    end
    points_seen++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        win_x[i] = '0;
        win_y[i] = '0;
      end
      held      = 0;
      bias_q    = BIAS_RESET;
      tension_q = TENSION_RESET;
      points_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BIAS) bias_q = cfg_data;
        else if (cfg_index == CFG_TENSION) tension_q = cfg_data;
      end
      if (m_tvalid && m_tready) check_point();
      if (s_tvalid && s_tready)
        smooth_sample(s_tdata[CW-1:0], s_tdata[2*CW-1:CW], s_tuser);
    end
    pending        <= points_due.size();
    mismatches     <= errors_seen;
    points_checked <= points_seen;
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

  import hss_pkg::*;

  localparam int SUBDIVISIONS   = 4;
  localparam int COORD_WIDTH    = 20;
  localparam int COEF_FRAC_BITS = 8;
  localparam int CW             = COORD_WIDTH;
  localparam int TDATA_W        = ((2*COORD_WIDTH+7)/8)*8;

  localparam int COORD_MAX = (1 << (CW - 1)) - 1;
  localparam int COORD_MIN = -(1 << (CW - 1));

  // Indexes past the two registers; the block drops these writes.
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_HI = 2'd3;

  localparam int RESET_CYCLES    = 9;
  localparam int SETTLE_CYCLES   = 16;
  localparam int TAIL_CYCLES     = 400;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int PHASE_SAMPLES   = 20;
  localparam int RANDOM_PHASES   = 6;

  logic                        clk;
  logic                        rst;
  logic                        s_tvalid;
  logic                        s_tready;
  logic [TDATA_W-1:0]          s_tdata;
  logic                        s_tuser;
  logic                        m_tvalid;
  logic                        m_tready;
  logic [TDATA_W-1:0]          m_tdata;
  logic                        m_tuser;
  logic                        m_tlast;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0]  cfg_index;
  logic [REG_WIDTH-1:0]        cfg_data;

  int mismatches;
  int pending;
  int points_checked;

  int tx_idle_pct;
  int rx_idle_pct;
  int samples_sent;
  int strokes_started;
  int settings_used;
  int phase_sent;

  hermite_stroke_smoother #(
    .SUBDIVISIONS  (SUBDIVISIONS),
    .COORD_WIDTH   (COORD_WIDTH),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  hss_checker #(
    .SUBDIVISIONS  (SUBDIVISIONS),
    .COORD_WIDTH   (COORD_WIDTH),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .pending       (pending),
    .points_checked(points_checked)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Run stopped at the cycle limit with %0d path points still due.", pending);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int clamp_coord(input int v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  function automatic int full_range_coord();
    int v;
    v = $urandom_range(0, (1 << CW) - 1);
    return v + COORD_MIN;
  endfunction

  // The beat is left up on return so the next sample can follow without a gap.
  task automatic send_sample(input int x, input int y, input bit start);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= TDATA_W'({y[CW-1:0], x[CW-1:0]});
    s_tuser  <= start;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    samples_sent++;
    if (start) strokes_started++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [REG_WIDTH-1:0] val, input bit final_write);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (final_write) cfg_valid <= 1'b0;
  endtask

  // Second and third samples give no point, so a short pause follows the
  // last point before the block counts as idle.
  task automatic wait_idle(input int pause);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (pause) @(posedge clk);
  endtask

  task automatic set_idle_mix(input int phase);
    case (phase / 2)
      0: begin
        tx_idle_pct = 14;
        rx_idle_pct = 74;
      end
      1: begin
        tx_idle_pct = 74;
        rx_idle_pct = 14;
      end
      default: begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
    endcase
  endtask

  task automatic program_phase(input int phase);
    case (phase)
      0: begin
        write_reg(CFG_BIAS, 11'sd0, 1'b0);
        write_reg(CFG_TENSION, 11'sd0, 1'b1);
      end
      1: begin
        write_reg(CFG_BIAS, 11'sd512, 1'b0);
        write_reg(CFG_TENSION, -11'sd512, 1'b1);
      end
      2: begin
        write_reg(CFG_TENSION, 11'sd512, 1'b0);
        write_reg(CFG_BIAS, -11'sd512, 1'b1);
      end
      3: begin
        // Writes to the unused indexes must leave both registers alone.
        write_reg(CFG_BIAS, 11'h3FF, 1'b0);
        write_reg(CFG_TENSION, 11'h400, 1'b0);
        write_reg(CFG_SPARE_LO, REG_WIDTH'($urandom), 1'b0);
        write_reg(CFG_SPARE_HI, REG_WIDTH'($urandom), 1'b1);
      end
      4: begin
        write_reg(CFG_BIAS, REG_WIDTH'($urandom), 1'b0);
        write_reg(CFG_TENSION, REG_WIDTH'($urandom), 1'b1);
      end
      default: begin
        write_reg(CFG_BIAS, BIAS_RESET, 1'b0);
        write_reg(CFG_TENSION, TENSION_RESET, 1'b1);
      end
    endcase
    settings_used++;
  endtask

  // Mostly full strokes long enough to reach the Hermite window; the rest are
  // cut short or lack their start flag.
  task automatic random_stroke();
    int len;
    int style;
    int cx;
    int cy;
    bit first_flag;
    bit start;
    if ($urandom_range(0, 99) < 75) len = $urandom_range(4, 12);
    else len = $urandom_range(1, 3);
    style      = $urandom_range(0, 99);
    first_flag = ($urandom_range(0, 99) < 90);
    cx = $urandom_range(0, 1 << (CW - 1)) - (1 << (CW - 2));
    cy = $urandom_range(0, 1 << (CW - 1)) - (1 << (CW - 2));
    for (int k = 0; k < len; k++) begin
      if (style < 15) begin
        cx = full_range_coord();
        cy = full_range_coord();
      end else if (style < 25) begin
        cx = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
        cy = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
      end else begin
        cx = clamp_coord(cx + $urandom_range(0, 8000) - 4000);
        cy = clamp_coord(cy + $urandom_range(0, 8000) - 4000);
      end
      if (k == 0) start = first_flag;
      else start = ($urandom_range(0, 99) < 3);
      send_sample(cx, cy, start);
      phase_sent++;
    end
  endtask

  initial begin
    rst             = 1'b1;
    s_tvalid        = 1'b0;
    s_tdata         = '0;
    s_tuser         = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_BIAS;
    cfg_data        = '0;
    tx_idle_pct     = 0;
    rx_idle_pct     = 0;
    samples_sent    = 0;
    strokes_started = 0;
    settings_used   = 1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset bias and tension.
    set_idle_mix(0);
    send_sample(0, 0, 1'b0);                   // empty window acts as a stroke start
    send_sample(COORD_MAX, COORD_MAX, 1'b0);
    send_sample(COORD_MIN, COORD_MIN, 1'b0);
    send_sample(COORD_MAX, COORD_MAX, 1'b0);   // first full window, saturating
    send_sample(COORD_MIN, COORD_MIN, 1'b0);
    send_sample(COORD_MAX, COORD_MIN, 1'b0);
    send_sample(COORD_MIN, COORD_MAX, 1'b0);
    send_sample(COORD_MIN, COORD_MAX, 1'b1);
    send_sample(0, 0, 1'b0);
    send_sample(1, -1, 1'b1);                  // restart with only two samples held
    send_sample(2, 3, 1'b0);
    send_sample(-2, -3, 1'b0);
    send_sample(32'h55555, 32'hAAAAA, 1'b0);
    send_sample(32'hAAAAA, 32'h55555, 1'b0);
    send_sample(-1, -1, 1'b0);
    send_sample(0, 0, 1'b0);
    send_sample(100, 200, 1'b1);
    send_sample(116, 260, 1'b0);
    send_sample(132, 230, 1'b0);
    send_sample(148, 300, 1'b0);
    send_sample(164, 310, 1'b0);
    send_sample(180, 150, 1'b0);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle(SETTLE_CYCLES);
      program_phase(phase);
      set_idle_mix(phase);
      phase_sent = 0;
      while (phase_sent < PHASE_SAMPLES) random_stroke();
    end

    wait_idle(TAIL_CYCLES);
    $display("Sent %0d pen samples, %0d flagged as stroke starts, over %0d bias/tension",
             samples_sent, strokes_started, settings_used);
    $display("settings and three stall mixes; %0d path points were checked.",
             points_checked);
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
